@@ hw/rtl/image_fit_rectangle_defines.svh @@
// ----------------------------------------------------------------------------
// image_fit_rectangle_defines.svh
// Assertion macros shared by the image fit rectangle block.
// ----------------------------------------------------------------------------
`ifndef IMAGE_FIT_RECTANGLE_DEFINES_SVH
`define IMAGE_FIT_RECTANGLE_DEFINES_SVH

// Same-cycle implication, switched off during reset.
`define IFR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off during reset.
`define IFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ifr_pkg.sv @@
// ----------------------------------------------------------------------------
// ifr_pkg
// Types, codes and defaults shared by the image fit rectangle block.
// ----------------------------------------------------------------------------
package ifr_pkg;

  localparam int unsigned FRAC_BITS_DEF = 8;
  localparam int unsigned INT_BITS_DEF  = 16;

  // Scale register is unsigned Q8.8 when FRAC_BITS is 8.
  localparam int unsigned SCALE_W = 16;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

  localparam int unsigned MODE_W    = 5;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_FIT_MODE = 2'd0;
  localparam cfg_idx_t REG_SCALE    = 2'd1;

  localparam mode_t MODE_FILL         = 5'd0;
  localparam mode_t MODE_CONTAIN      = 5'd1;
  localparam mode_t MODE_COVER        = 5'd2;
  localparam mode_t MODE_FIT_W        = 5'd3;
  localparam mode_t MODE_FIT_H        = 5'd4;
  localparam mode_t MODE_NONE         = 5'd5;
  localparam mode_t MODE_SCALE_DOWN   = 5'd6;
  localparam mode_t MODE_TOP_LEFT     = 5'd7;
  localparam mode_t MODE_TOP          = 5'd8;
  localparam mode_t MODE_TOP_RIGHT    = 5'd9;
  localparam mode_t MODE_LEFT         = 5'd10;
  localparam mode_t MODE_CENTER       = 5'd11;
  localparam mode_t MODE_RIGHT        = 5'd12;
  localparam mode_t MODE_BOTTOM_LEFT  = 5'd13;
  localparam mode_t MODE_BOTTOM       = 5'd14;
  localparam mode_t MODE_BOTTOM_RIGHT = 5'd15;
  localparam mode_t MODE_MATRIX       = 5'd16;
  localparam mode_t MODE_COVER_TL     = 5'd17;

  typedef enum logic [1:0] {
    ANC_START = 2'd0,
    ANC_MID   = 2'd1,
    ANC_END   = 2'd2
  } anc_t;

  typedef enum logic [1:0] {
    SRC_FRAME  = 2'd0,
    SRC_SCALED = 2'd1,
    SRC_RATIO  = 2'd2
  } lane_src_t;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } div_stat_t;

  function automatic anc_t anchor_x(input mode_t mode);
    case (mode) inside
      MODE_TOP, MODE_CENTER, MODE_BOTTOM:                 return ANC_MID;
      MODE_TOP_RIGHT, MODE_RIGHT, MODE_BOTTOM_RIGHT:      return ANC_END;
      default:                                            return ANC_START;
    endcase
  endfunction

  function automatic anc_t anchor_y(input mode_t mode);
    case (mode) inside
      MODE_LEFT, MODE_CENTER, MODE_RIGHT:                 return ANC_MID;
      MODE_BOTTOM_LEFT, MODE_BOTTOM, MODE_BOTTOM_RIGHT:   return ANC_END;
      default:                                            return ANC_START;
    endcase
  endfunction

endpackage

@@ hw/rtl/ifr_mul.sv @@
// ----------------------------------------------------------------------------
// ifr_mul
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ifr_mul #(
  parameter int unsigned A_W = 24,
  parameter int unsigned B_W = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] prod,
  output logic               done
);
  localparam int unsigned P_W   = A_W + B_W;
  localparam int unsigned CNT_W = $clog2(B_W + 1);

  logic [P_W-1:0]   acc;
  logic [P_W-1:0]   mcand;
  logic [B_W-1:0]   mplier;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(B_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= P_W'(a);
      mplier <= b;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  assign prod = acc;

endmodule

@@ hw/rtl/ifr_div.sv @@
// ----------------------------------------------------------------------------
// ifr_div
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ifr_div #(
  parameter int unsigned NUM_W = 56,
  parameter int unsigned DEN_W = 41
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_W-1:0]    num,
  input  logic [DEN_W-1:0]    den,
  output logic [NUM_W-1:0]    quot,
  output ifr_pkg::div_stat_t  stat
);
  import ifr_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem, quo[NUM_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dvs <= den;
    end else if (busy) begin
      rem <= ge ? DEN_W'(trial - {1'b0, dvs}) : DEN_W'(trial);
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

  assign quot        = quo;
  assign stat.done   = done;
  assign stat.rem_nz = |rem;

endmodule

@@ hw/rtl/image_fit_rectangle.sv @@
// ----------------------------------------------------------------------------
// image_fit_rectangle
// Places a scaled source image inside a frame according to a fit mode.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  src      in         src_valid/src_stall  source_width/height, frame_width/height
//  res      out        res_valid/res_stall  place_left/top/width/height, kept_previous
//  cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each item runs three serial divisions and one serial multiplication, one
// bit per cycle; a new item is accepted only once the block is back in idle.
// Zero-size and anchor items finish after the scaling division.
// Reset is synchronous and clears the held rectangle, the state and the config registers.
// A new item is taken while a result waits; a stalled result holds the block
// in its final state until it is taken.
// ----------------------------------------------------------------------------
`include "image_fit_rectangle_defines.svh"

module image_fit_rectangle #(
  parameter int unsigned FRAC_BITS = ifr_pkg::FRAC_BITS_DEF,
  parameter int unsigned INT_BITS  = ifr_pkg::INT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                src_valid,
  output logic                                src_stall,
  input  logic [INT_BITS+FRAC_BITS-1:0]       source_width,
  input  logic [INT_BITS+FRAC_BITS-1:0]       source_height,
  input  logic [INT_BITS+FRAC_BITS-1:0]       frame_width,
  input  logic [INT_BITS+FRAC_BITS-1:0]       frame_height,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic signed [INT_BITS+FRAC_BITS:0]  place_left,
  output logic signed [INT_BITS+FRAC_BITS:0]  place_top,
  output logic [INT_BITS+FRAC_BITS-1:0]       place_width,
  output logic [INT_BITS+FRAC_BITS-1:0]       place_height,
  output logic                                kept_previous,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  ifr_pkg::cfg_idx_t                   cfg_index,
  input  logic [ifr_pkg::SCALE_W-1:0]         cfg_data
);
  import ifr_pkg::*;

  localparam int unsigned SZ_W  = INT_BITS + FRAC_BITS;
  localparam int unsigned SW_W  = SZ_W + FRAC_BITS;
  localparam int unsigned P_W   = SZ_W + SW_W;
  localparam int unsigned OFF_W = SZ_W + 1;
  localparam int unsigned PIX_W = INT_BITS;
  localparam int unsigned DD_W  =
    (SW_W + FRAC_BITS + 1 > SCALE_W) ? SW_W + FRAC_BITS + 1 : SCALE_W;
  localparam logic [SZ_W-1:0] SZ_MAX = '1;

  typedef enum logic [10:0] {
    S_IDLE        = 11'b00000000001,
    S_SCALE       = 11'b00000000010,
    S_SCALE_WAIT  = 11'b00000000100,
    S_CHECK       = 11'b00000001000,
    S_MUL_WAIT    = 11'b00000010000,
    S_PREP        = 11'b00000100000,
    S_CEIL        = 11'b00001000000,
    S_CEIL_WAIT   = 11'b00010000000,
    S_CENTER      = 11'b00100000000,
    S_CENTER_WAIT = 11'b01000000000,
    S_DONE        = 11'b10000000000
  } state_t;

  state_t state, state_next;

  mode_t            fit_mode;
  logic [SCALE_W-1:0] scale_factor;

  logic [SZ_W-1:0]  src_w, src_h, frm_w, frm_h;
  logic [SW_W-1:0]  sw, sh;
  logic [P_W-1:0]   num_w, num_h, acc_w, acc_h;
  logic [SW_W-1:0]  den_w, den_h;
  logic             neg_w, neg_h;
  logic [OFF_W-1:0] r_left, r_top;
  logic [SZ_W-1:0]  r_width, r_height;
  logic             kept_r;

  logic [OFF_W-1:0] held_left, held_top;
  logic [SZ_W-1:0]  held_width, held_height;
  logic             kept_out;

  logic             div_start;
  logic [P_W-1:0]   div_num_w, div_num_h, quot_w, quot_h;
  logic [DD_W-1:0]  div_den_w, div_den_h;
  div_stat_t        dstat_w, dstat_h;

  logic             mul_start, mul_done_w, mul_done_h;
  logic [P_W-1:0]   p1, p2;

  logic [P_W-1:0]   diff_w, diff_h;
  logic             take_min, frame_w_wins, frame_h_wins, small_src;
  lane_src_t        lane_w, lane_h;
  logic             is_anchor, zero_src, out_free;

  // -------------------------------------------------------------- helpers
  function automatic logic [SZ_W-1:0] sat_mag(input logic [SW_W:0] v);
    if (v > (SW_W+1)'(SZ_MAX)) return SZ_MAX;
    return v[SZ_W-1:0];
  endfunction

  function automatic logic [OFF_W-1:0] sgn(input logic neg, input logic [SZ_W-1:0] mag);
    return neg ? -{1'b0, mag} : {1'b0, mag};
  endfunction

  // Quotient to whole pixels, saturated at the field maximum.
  function automatic logic [SZ_W-1:0] pix_sat(input logic [P_W:0] c);
    if (|c[P_W:PIX_W]) return SZ_MAX;
    return SZ_W'(c[PIX_W-1:0]) << FRAC_BITS;
  endfunction

  function automatic logic [OFF_W-1:0] anchor_off(input anc_t sel,
                                                  input logic [SZ_W-1:0] f,
                                                  input logic [SW_W-1:0] s);
    logic [SW_W:0] fe, se, m, h;
    logic          neg;
    fe  = (SW_W+1)'(f);
    se  = {1'b0, s};
    neg = fe < se;
    m   = neg ? se - fe : fe - se;
    if (sel == ANC_MID) h = neg ? (m + 1'b1) >> 1 : m >> 1;
    else h = m;
    if (sel == ANC_START) return '0;
    return sgn(neg, sat_mag(h));
  endfunction

  // -------------------------------------------------------------- units
  ifr_mul #(.A_W(SZ_W), .B_W(SW_W)) u_mul_w (
    .clk(clk), .rst(rst), .start(mul_start), .a(frm_w), .b(sh),
    .prod(p1), .done(mul_done_w)
  );

  ifr_mul #(.A_W(SZ_W), .B_W(SW_W)) u_mul_h (
    .clk(clk), .rst(rst), .start(mul_start), .a(frm_h), .b(sw),
    .prod(p2), .done(mul_done_h)
  );

  ifr_div #(.NUM_W(P_W), .DEN_W(DD_W)) u_div_w (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num_w), .den(div_den_w),
    .quot(quot_w), .stat(dstat_w)
  );

  ifr_div #(.NUM_W(P_W), .DEN_W(DD_W)) u_div_h (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num_h), .den(div_den_h),
    .quot(quot_h), .stat(dstat_h)
  );

  // -------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode     <= MODE_CONTAIN;
      scale_factor <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FIT_MODE: fit_mode     <= cfg_data[MODE_W-1:0];
        REG_SCALE:    scale_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------- decode
  assign is_anchor = (fit_mode >= MODE_TOP_LEFT) && (fit_mode <= MODE_MATRIX);
  assign zero_src  = (sw == '0) || (sh == '0);
  assign take_min  = !((fit_mode == MODE_COVER) || (fit_mode == MODE_COVER_TL));
  assign frame_w_wins = take_min ? (p1 <= p2) : (p1 >= p2);
  assign frame_h_wins = take_min ? (p2 <= p1) : (p2 >= p1);
  assign small_src = (sw < SW_W'(frm_w)) && (sh < SW_W'(frm_h));
  assign out_free  = !res_valid || !res_stall;

  always_comb begin
    lane_w = frame_w_wins ? SRC_FRAME : SRC_RATIO;
    lane_h = frame_h_wins ? SRC_FRAME : SRC_RATIO;
    unique case (fit_mode)
      MODE_FILL: begin
        lane_w = SRC_FRAME;
        lane_h = SRC_FRAME;
      end
      MODE_FIT_W: begin
        lane_w = SRC_FRAME;
        lane_h = SRC_RATIO;
      end
      MODE_FIT_H: begin
        lane_w = SRC_RATIO;
        lane_h = SRC_FRAME;
      end
      MODE_NONE: begin
        lane_w = SRC_SCALED;
        lane_h = SRC_SCALED;
      end
      MODE_SCALE_DOWN: begin
        if (small_src) begin
          lane_w = SRC_SCALED;
          lane_h = SRC_SCALED;
        end
      end
      default: ;
    endcase
  end

  assign diff_w = (acc_w >= num_w) ? acc_w - num_w : num_w - acc_w;
  assign diff_h = (acc_h >= num_h) ? acc_h - num_h : num_h - acc_h;

  always_comb begin
    div_num_w = num_w;
    div_num_h = num_h;
    div_den_w = DD_W'(den_w) << FRAC_BITS;
    div_den_h = DD_W'(den_h) << FRAC_BITS;
    if (state == S_SCALE) begin
      div_num_w = P_W'(src_w) << FRAC_BITS;
      div_num_h = P_W'(src_h) << FRAC_BITS;
      div_den_w = DD_W'(scale_factor);
      div_den_h = DD_W'(scale_factor);
    end else if (state == S_CENTER) begin
      div_num_w = diff_w;
      div_num_h = diff_h;
      div_den_w = DD_W'(den_w) << (FRAC_BITS + 1);
      div_den_h = DD_W'(den_h) << (FRAC_BITS + 1);
    end
  end

  assign div_start = ((state == S_SCALE) && (scale_factor != '0))
                     || (state == S_CEIL) || (state == S_CENTER);
  assign mul_start = (state == S_CHECK) && !zero_src && !is_anchor;

  // -------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:        if (src_valid) state_next = S_SCALE;
      S_SCALE:       state_next = (scale_factor == '0) ? S_DONE : S_SCALE_WAIT;
      S_SCALE_WAIT:  if (dstat_w.done) state_next = S_CHECK;
      S_CHECK:       state_next = (zero_src || is_anchor) ? S_DONE : S_MUL_WAIT;
      S_MUL_WAIT:    if (mul_done_w) state_next = S_PREP;
      S_PREP:        state_next = S_CEIL;
      S_CEIL:        state_next = S_CEIL_WAIT;
      S_CEIL_WAIT:   if (dstat_w.done) state_next = S_CENTER;
      S_CENTER:      state_next = S_CENTER_WAIT;
      S_CENTER_WAIT: if (dstat_w.done) state_next = S_DONE;
      S_DONE:        if (out_free) state_next = S_IDLE;
      default:       state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign src_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        src_w <= source_width;
        src_h <= source_height;
        frm_w <= frame_width;
        frm_h <= frame_height;
        kept_r <= 1'b1;
      end
      S_SCALE_WAIT: begin
        sw <= quot_w[SW_W-1:0];
        sh <= quot_h[SW_W-1:0];
      end
      S_CHECK: begin
        if (!zero_src) begin
          kept_r <= 1'b0;
        end
        r_left   <= anchor_off(anchor_x(fit_mode), frm_w, sw);
        r_top    <= anchor_off(anchor_y(fit_mode), frm_h, sh);
        r_width  <= sat_mag({1'b0, sw});
        r_height <= sat_mag({1'b0, sh});
      end
      S_PREP: begin
        case (lane_w)
          SRC_SCALED: begin
            num_w <= P_W'(sw);
            den_w <= SW_W'(1);
            acc_w <= P_W'(frm_w);
          end
          SRC_RATIO: begin
            num_w <= p2;
            den_w <= sh;
            acc_w <= p1;
          end
          default: begin
            num_w <= P_W'(frm_w);
            den_w <= SW_W'(1);
            acc_w <= P_W'(frm_w);
          end
        endcase
        case (lane_h)
          SRC_SCALED: begin
            num_h <= P_W'(sh);
            den_h <= SW_W'(1);
            acc_h <= P_W'(frm_h);
          end
          SRC_RATIO: begin
            num_h <= p1;
            den_h <= sw;
            acc_h <= p2;
          end
          default: begin
            num_h <= P_W'(frm_h);
            den_h <= SW_W'(1);
            acc_h <= P_W'(frm_h);
          end
        endcase
      end
      S_CEIL_WAIT: begin
        if (dstat_w.done) begin
          r_width  <= pix_sat({1'b0, quot_w} + (P_W+1)'(dstat_w.rem_nz));
          r_height <= pix_sat({1'b0, quot_h} + (P_W+1)'(dstat_h.rem_nz));
        end
      end
      S_CENTER: begin
        neg_w <= acc_w < num_w;
        neg_h <= acc_h < num_h;
      end
      S_CENTER_WAIT: begin
        // A negative offset rounds its magnitude up, so that the pixel
        // offset is the floor of the signed value.
        if (dstat_w.done) begin
          if (fit_mode == MODE_COVER_TL) begin
            r_left <= '0;
            r_top  <= '0;
          end else begin
            r_left <= sgn(neg_w, pix_sat({1'b0, quot_w}
                                         + (P_W+1)'(neg_w && dstat_w.rem_nz)));
            r_top  <= sgn(neg_h, pix_sat({1'b0, quot_h}
                                         + (P_W+1)'(neg_h && dstat_h.rem_nz)));
          end
        end
      end
      default: ;
    endcase
  end

  // -------------------------------------------------------------- result
  // The held rectangle doubles as the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid   <= 1'b0;
      kept_out    <= 1'b0;
      held_left   <= '0;
      held_top    <= '0;
      held_width  <= '0;
      held_height <= '0;
    end else begin
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      if ((state == S_DONE) && out_free) begin
        res_valid <= 1'b1;
        kept_out  <= kept_r;
        if (!kept_r) begin
          held_left   <= r_left;
          held_top    <= r_top;
          held_width  <= r_width;
          held_height <= r_height;
        end
      end
    end
  end

  assign place_left    = held_left;
  assign place_top     = held_top;
  assign place_width   = held_width;
  assign place_height  = held_height;
  assign kept_previous = kept_out;

  // -------------------------------------------------------------- checks
  `IFR_ASSERT_NEXT(a_accept_starts, clk, rst, src_valid && !src_stall, state == S_SCALE, "accepted item did not start scaling")
  `IFR_ASSERT_IMPL(a_result_from_done, clk, rst, $rose(res_valid), $past(state) == S_DONE, "result raised outside final state")
  `IFR_ASSERT_IMPL(a_lanes_in_step, clk, rst, 1'b1, (dstat_w.done == dstat_h.done) && (mul_done_w == mul_done_h), "serial lanes out of step")
  `IFR_ASSERT_IMPL(a_kept_holds, clk, rst, $rose(res_valid) && kept_previous, $stable(held_width) && $stable(held_left), "kept item changed the rectangle")

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// Image fit rectangle testbench
// Drives source and frame sizes through every fit mode and extreme and random scale settings.
// A predictor in the bench works out each placed rectangle and a checker
// compares every result, field by field, while both sides idle and stall.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ifr_pkg::*;

  localparam logic [63:0] SIZE_MAX  = 64'hFF_FFFF;
  localparam logic [63:0] PIX_MAX   = SIZE_MAX >> 8;
  localparam int          CYCLE_CAP = 3000000;
  localparam int          SETTLE    = 250;

  typedef struct packed {
    logic signed [24:0] left;
    logic signed [24:0] top;
    logic [23:0]        width;
    logic [23:0]        height;
    logic               kept;
  } rect_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                src_valid = 1'b0;
  logic                src_stall;
  logic [23:0]         source_width = '0;
  logic [23:0]         source_height = '0;
  logic [23:0]         frame_width = '0;
  logic [23:0]         frame_height = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  logic signed [24:0]  place_left;
  logic signed [24:0]  place_top;
  logic [23:0]         place_width;
  logic [23:0]         place_height;
  logic                kept_previous;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_idx_t            cfg_index = REG_FIT_MODE;
  logic [SCALE_W-1:0]  cfg_data = '0;

  // Bench copy of the registers and of the held rectangle.
  mode_t               cur_mode = MODE_CONTAIN;
  logic [15:0]         cur_scale = SCALE_RESET;
  rect_t               held_rect = '0;

  rect_t               pending_rects[$];
  int                  idle_pct = 0;
  int                  stall_pct = 0;
  int                  hold_cycles = 0;
  int                  cycle_count = 0;
  int                  items_sent = 0;
  int                  results_seen = 0;
  int                  kept_seen = 0;
  int                  errors = 0;

  image_fit_rectangle u_dut (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall),
    .source_width(source_width), .source_height(source_height),
    .frame_width(frame_width), .frame_height(frame_height),
    .res_valid(res_valid), .res_stall(res_stall),
    .place_left(place_left), .place_top(place_top),
    .place_width(place_width), .place_height(place_height),
    .kept_previous(kept_previous),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: a long hold-off takes precedence over random stalling.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      res_stall = 1'b1;
      hold_cycles--;
    end else begin
      res_stall = ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    rect_t want;
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (pending_rects.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        want = pending_rects.pop_front();
        if (kept_previous) kept_seen++;
        if (place_left !== want.left) begin
          $error("place_left expected %0d got %0d", want.left, place_left);
          errors++;
        end
        if (place_top !== want.top) begin
          $error("place_top expected %0d got %0d", want.top, place_top);
          errors++;
        end
        if (place_width !== want.width) begin
          $error("place_width expected %0d got %0d", want.width, place_width);
          errors++;
        end
        if (place_height !== want.height) begin
          $error("place_height expected %0d got %0d", want.height, place_height);
          errors++;
        end
        if (kept_previous !== want.kept) begin
          $error("kept_previous expected %0d got %0d", want.kept, kept_previous);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [24:0] clamp_offset(input logic neg, input logic [63:0] mag);
    longint m;
    m = (mag > SIZE_MAX) ? longint'(SIZE_MAX) : longint'(mag);
    return neg ? 25'(-m) : 25'(m);
  endfunction

  function automatic logic [23:0] round_up_pixel(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] d;
    logic [63:0] c;
    d = den << 8;
    c = num / d + ((num % d) != 0 ? 64'd1 : 64'd0);
    if (c > PIX_MAX) return SIZE_MAX[23:0];
    return 24'(c << 8);
  endfunction

  // Half the spare room, rounded down to a whole pixel.
  function automatic logic signed [24:0] centre_offset(input logic [63:0] f,
                                                        input logic [63:0] num,
                                                        input logic [63:0] den);
    logic [63:0] a;
    logic [63:0] d;
    logic [63:0] m;
    logic [63:0] p;
    a = f * den;
    d = den << 9;
    if (a >= num) begin
      p = (a - num) / d;
      if (p > PIX_MAX) return clamp_offset(1'b0, SIZE_MAX);
      return clamp_offset(1'b0, p << 8);
    end
    m = num - a;
    p = m / d + ((m % d) != 0 ? 64'd1 : 64'd0);
    if (p > PIX_MAX) return clamp_offset(1'b1, SIZE_MAX);
    return clamp_offset(1'b1, p << 8);
  endfunction

  function automatic logic signed [24:0] anchored_offset(input anc_t sel, input logic [63:0] f,
                                                          input logic [63:0] s);
    logic [63:0] m;
    if (sel == ANC_START) return '0;
    if (f >= s) begin
      m = f - s;
      return clamp_offset(1'b0, sel == ANC_MID ? (m >> 1) : m);
    end
    m = s - f;
    return clamp_offset(1'b1, sel == ANC_MID ? ((m + 1) >> 1) : m);
  endfunction

  function automatic void aspect_sizes(input logic take_min, input logic [63:0] fw, fh, sw, sh,
                                       output logic [63:0] wn, wd, hn, hd);
    logic [63:0] by_w;
    logic [63:0] by_h;
    logic        use_fw;
    logic        use_fh;
    by_w = fw * sh;
    by_h = fh * sw;
    use_fw = take_min ? (by_w <= by_h) : (by_w >= by_h);
    use_fh = take_min ? (by_h <= by_w) : (by_h >= by_w);
    if (use_fw) begin wn = fw; wd = 1; end else begin wn = fh * sw; wd = sh; end
    if (use_fh) begin hn = fh; hd = 1; end else begin hn = fw * sh; hd = sw; end
  endfunction

  function automatic rect_t predict_placement(input logic [23:0] s_w, s_h, f_w, f_h);
    logic [63:0] sw;
    logic [63:0] sh;
    logic [63:0] fw;
    logic [63:0] fh;
    logic [63:0] wn;
    logic [63:0] wd;
    logic [63:0] hn;
    logic [63:0] hd;
    int          k;
    rect_t       r;
    fw = 64'(f_w);
    fh = 64'(f_h);
    r = held_rect;
    r.kept = 1'b1;
    if (cur_scale != 0) begin
      sw = (64'(s_w) << 8) / cur_scale;
      sh = (64'(s_h) << 8) / cur_scale;
      if (sw != 0 && sh != 0) begin
        r.kept = 1'b0;
        if (cur_mode >= MODE_TOP_LEFT && cur_mode <= MODE_MATRIX) begin
          k = (cur_mode == MODE_MATRIX) ? 0 : int'(cur_mode - MODE_TOP_LEFT);
          r.left   = anchored_offset(anc_t'(k % 3), fw, sw);
          r.top    = anchored_offset(anc_t'(k / 3), fh, sh);
          r.width  = (sw > SIZE_MAX) ? SIZE_MAX[23:0] : sw[23:0];
          r.height = (sh > SIZE_MAX) ? SIZE_MAX[23:0] : sh[23:0];
        end else begin
          wn = fw; wd = 1; hn = fh; hd = 1;
          case (cur_mode)
            MODE_FILL: ;
            MODE_COVER, MODE_COVER_TL: aspect_sizes(1'b0, fw, fh, sw, sh, wn, wd, hn, hd);
            MODE_FIT_W: begin hn = fw * sh; hd = sw; end
            MODE_FIT_H: begin wn = fh * sw; wd = sh; end
            MODE_NONE: begin wn = sw; hn = sh; end
            MODE_SCALE_DOWN: begin
              if (sw < fw && sh < fh) begin
                wn = sw;
                hn = sh;
              end else begin
                aspect_sizes(1'b1, fw, fh, sw, sh, wn, wd, hn, hd);
              end
            end
            default: aspect_sizes(1'b1, fw, fh, sw, sh, wn, wd, hn, hd);
          endcase
          if (cur_mode == MODE_COVER_TL) begin
            r.left = '0;
            r.top  = '0;
          end else begin
            r.left = centre_offset(fw, wn, wd);
            r.top  = centre_offset(fh, hn, hd);
          end
          r.width  = round_up_pixel(wn, wd);
          r.height = round_up_pixel(hn, hd);
        end
        held_rect = r;
        held_rect.kept = 1'b0;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [23:0] s_w, s_h, f_w, f_h);
    while ($urandom_range(99) < idle_pct) begin
      src_valid = 1'b0;
      @(negedge clk);
    end
    source_width  = s_w;
    source_height = s_h;
    frame_width   = f_w;
    frame_height  = f_h;
    src_valid     = 1'b1;
    forever begin
      @(posedge clk);
      if (!src_stall) break;
    end
    pending_rects.push_back(predict_placement(s_w, s_h, f_w, f_h));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    src_valid = 1'b0;
    while (pending_rects.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    wait_idle();
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    if (idx == REG_FIT_MODE) cur_mode = value[MODE_W-1:0];
    else if (idx == REG_SCALE) cur_scale = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [23:0] pick_size();
    case ($urandom_range(9))
      0, 1, 2: return 24'($urandom);
      3:       return 24'hFF_FFFF;
      4:       return 24'($urandom_range(0, 3));
      default: return 24'($urandom_range(1, 2048) << 8) | 24'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(7))
      0:       return 16'd1;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 65535));
      3:       return 16'($urandom_range(64, 1024));
      default: return SCALE_RESET;
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    send_item(24'd0, 24'd100 << 8, 24'd100 << 8, 24'd100 << 8);
    send_item(24'd640 << 8, 24'd480 << 8, 24'd320 << 8, 24'd320 << 8);
    send_item(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    send_item(24'd1, 24'd1, 24'd0, 24'd0);
    send_item(24'd100 << 8, 24'd0, 24'd50 << 8, 24'd50 << 8);
  endtask

  task automatic test_every_mode();
    mode_t m;
    for (int i = 0; i <= MODE_COVER_TL; i++) begin
      m = mode_t'(i);
      write_reg(REG_FIT_MODE, 16'(m));
      send_item(24'd300 << 8 | 24'd77, 24'd200 << 8, 24'd120 << 8 | 24'd3, 24'd90 << 8);
    end
    // An unlisted code falls back to contain.
    write_reg(REG_FIT_MODE, 16'h001F);
    send_item(24'd300 << 8, 24'd200 << 8, 24'd120 << 8, 24'd90 << 8);
  endtask

  task automatic test_scale_extremes();
    write_reg(REG_FIT_MODE, 16'(MODE_NONE));
    write_reg(REG_SCALE, 16'd1);
    send_item(24'hFF_FFFF, 24'hFF_FFFF, 24'd10 << 8, 24'd10 << 8);
    write_reg(REG_SCALE, 16'hFFFF);
    send_item(24'd100, 24'd5000, 24'd10 << 8, 24'd10 << 8);
    write_reg(REG_SCALE, 16'd0);
    send_item(24'd100 << 8, 24'd100 << 8, 24'd10 << 8, 24'd10 << 8);
    // Writes to indexes past the scale register must leave it alone.
    write_reg(REG_SCALE + cfg_idx_t'(1), 16'h1234);
    write_reg(REG_SCALE + cfg_idx_t'(2), 16'h0007);
    send_item(24'd100 << 8, 24'd100 << 8, 24'd10 << 8, 24'd10 << 8);
    write_reg(REG_SCALE, SCALE_RESET);
  endtask

  task automatic test_random(input int count, input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      if (n % 25 == 0) begin
        write_reg(REG_FIT_MODE, ($urandom_range(9) < 8) ? 16'($urandom_range(0, 17))
                                                       : 16'($urandom_range(18, 31)));
        write_reg(REG_SCALE, pick_scale());
        idle_pct  = idle;
        stall_pct = stall;
      end
      send_item(pick_size(), pick_size(), pick_size(), pick_size());
    end
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    write_reg(REG_FIT_MODE, 16'(MODE_COVER));
    hold_cycles = 1500;
    for (int n = 0; n < 8; n++) send_item(pick_size(), pick_size(), pick_size(), pick_size());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_every_mode();
    test_scale_extremes();
    test_random(200, 0, 0);
    test_random(200, 71, 0);
    test_random(200, 0, 71);
    test_random(200, 35, 35);
    test_backpressure();
    wait_idle();
    repeat (SETTLE) @(negedge clk);
    $display("Covered %0d items over all fit modes and scale extremes, %0d kept rectangles.",
             items_sent, kept_seen);
    $display("%0d results checked, %0d mismatches.", results_seen, errors);
    if (errors == 0 && pending_rects.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/ifr_pkg.sv
hw/rtl/ifr_mul.sv
hw/rtl/ifr_div.sv
hw/rtl/image_fit_rectangle.sv
test/tb.sv
